// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL files of the learning table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mlt_pkg.sv -----
// Types and constants shared by the MAC learning table modules.
`timescale 1ns / 1ps
package mlt_pkg;

  localparam int MAC_W   = 48;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int TIME_W  = HOUR_W + MIN_W + SEC_W;
  localparam int FRAME_W = 32;
  localparam int SLOT_W  = 10;
  localparam int CFG_W   = 11;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 3;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 64;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int MIX_SHIFT = 33;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 11'd819;

  localparam logic [FUNC_W-1:0] FUNC_UPSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COUNT  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_UPDATED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FOUND    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_MISSING  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;

  typedef struct packed {
    logic               valid;
    logic [MAC_W-1:0]   key;
    logic [TIME_W-1:0]  tm;
    logic [FRAME_W-1:0] frame;
  } mlt_entry_t;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    logic [1:0]        mul_phase;
    logic              mul_sel;
    logic              mix;
    logic              seed;
    logic              step;
    logic              rd;
    logic              latch;
    logic              wr;
    logic              clr_wr;
    logic              cnt_inc;
    logic              res_load;
    logic              res_entry;
    logic [STAT_W-1:0] res_status;
  } mlt_cmd_t;

  typedef struct packed {
    logic              hit;
    logic              empty;
    logic              last;
    logic              full;
    logic [FUNC_W-1:0] func;
    logic              out_busy;
  } mlt_stat_t;

endpackage

// ----- rtl/core/mlt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/mlt_ctrl.sv -----
// Controller state machine: hash sequencing, probing, writes and result hand-off.
`timescale 1ns / 1ps
module mlt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mlt_pkg::mlt_stat_t st,
  output mlt_pkg::mlt_cmd_t  cmd
);
  import mlt_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_MIX   = 9'b000001000,
    S_SEED  = 9'b000010000,
    S_RD    = 9'b000100000,
    S_CHK   = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

  state_t            state, state_next;
  logic [1:0]        phase, phase_next;
  logic              csel, csel_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic              res_entry, res_entry_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    state_next      = state;
    phase_next      = phase;
    csel_next       = csel;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    cmd.res_status  = res_status;
    cmd.res_entry   = res_entry;
    cmd.mul_phase   = phase;
    cmd.mul_sel     = csel;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          phase_next = 2'd0;
          csel_next  = 1'b0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        phase_next = phase + 2'd1;
        if (phase == 2'd3) begin
          state_next = S_MIX;
        end
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        if (csel) begin
          state_next = S_SEED;
        end else begin
          csel_next  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_SEED: begin
        cmd.seed   = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.latch = 1'b1;
        if (st.hit) begin
          res_entry_next = 1'b1;
          if (st.func == FUNC_UPSERT) begin
            res_status_next = STAT_UPDATED;
            state_next      = S_WRITE;
          end else if (st.func == FUNC_COUNT) begin
            res_status_next = STAT_FOUND;
            state_next      = S_WRITE;
          end else begin
            res_status_next = STAT_FOUND;
            state_next      = S_RESP;
          end
        end else if (st.empty || st.last) begin
          // A miss on the last probe means every slot holds another key.
          if (st.func == FUNC_UPSERT && st.empty && !st.full) begin
            res_entry_next  = 1'b1;
            res_status_next = STAT_INSERTED;
            state_next      = S_WRITE;
          end else begin
            res_entry_next  = 1'b0;
            res_status_next = (st.func == FUNC_UPSERT) ? STAT_FULL : STAT_MISSING;
            state_next      = S_RESP;
          end
        end else begin
          cmd.step   = 1'b1;
          state_next = S_RD;
        end
      end
      S_WRITE: begin
        cmd.wr      = 1'b1;
        cmd.cnt_inc = (res_status == STAT_INSERTED);
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (!st.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      phase      <= 2'd0;
      csel       <= 1'b0;
      res_status <= STAT_MISSING;
      res_entry  <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      csel       <= csel_next;
      res_status <= res_status_next;
      res_entry  <= res_entry_next;
    end
  end

  `CHK_NEXT(a_accept_hash, clk, rst, in_valid && in_ready, state == S_MUL, "accept did not start hash")
  `CHK_SAME(a_resp_free, clk, rst, cmd.res_load, !st.out_busy, "result loaded over pending one")
  `CHK_SAME(a_insert_room, clk, rst, cmd.cnt_inc, !st.full, "insert past entry limit")

endmodule

// ----- rtl/core/mlt_dp.sv -----
// Datapath: hash unit, probe index, entry registers, limit check and result register.
`timescale 1ns / 1ps
module mlt_dp #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  mlt_pkg::mlt_cmd_t                       cmd,
  output mlt_pkg::mlt_stat_t                      st,
  input  logic [mlt_pkg::IN_W-1:0]                in_data,
  input  logic [mlt_pkg::FUNC_W-1:0]              in_user,
  input  logic                                    cfg_valid,
  input  logic [mlt_pkg::CFG_W-1:0]               cfg_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [mlt_pkg::OUT_W-1:0]               out_data,
  output logic [mlt_pkg::STAT_W-1:0]              out_user,
  output logic                                    ram_we,
  output logic [$clog2(TABLE_SLOTS)-1:0]          ram_waddr,
  output logic [$bits(mlt_pkg::mlt_entry_t)-1:0]  ram_wdata,
  output logic                                    ram_re,
  output logic [$clog2(TABLE_SLOTS)-1:0]          ram_raddr,
  input  logic [$bits(mlt_pkg::mlt_entry_t)-1:0]  ram_rdata
);
  import mlt_pkg::*;

  `include "assert_macros.svh"

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;

  logic [MAC_W-1:0]   key;
  logic [TIME_W-1:0]  tm;
  logic [FUNC_W-1:0]  func;
  logic [63:0]        h;
  logic [63:0]        acc;
  logic [63:0]        prod;
  logic [63:0]        kext;
  logic [63:0]        mconst;
  logic [31:0]        a_half, b_half;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      n;
  logic [CW-1:0]      count;
  logic [CFG_W-1:0]   max_entries;
  logic [TIME_W-1:0]  ent_time;
  logic [FRAME_W-1:0] ent_frame;
  mlt_entry_t         rd;
  mlt_entry_t         wr_ent;

  logic [SLOT_W-1:0]  o_slot;
  logic [TIME_W-1:0]  o_time;
  logic [FRAME_W-1:0] o_frame;
  logic [STAT_W-1:0]  o_status;

  assign kext   = {{(64 - MAC_W){1'b0}}, in_data[MAC_W-1:0]};
  assign mconst = cmd.mul_sel ? MIX_C2 : MIX_C1;
  assign a_half = (cmd.mul_phase == 2'd2) ? h[63:32] : h[31:0];
  assign b_half = (cmd.mul_phase == 2'd1) ? mconst[63:32] : mconst[31:0];

  assign rd = mlt_entry_t'(ram_rdata);

  // The low 64 bits of the product are built from three 32x32 partial products.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key  <= in_data[MAC_W-1:0];
      tm   <= {in_data[52:48], in_data[58:53], in_data[64:59]};
      func <= in_user;
      h    <= kext ^ (kext >> MIX_SHIFT);
    end else if (cmd.mix) begin
      h <= acc ^ (acc >> MIX_SHIFT);
    end
    if (cmd.mul_en) begin
      prod <= a_half * b_half;
      unique case (cmd.mul_phase)
        2'd0: acc <= acc;
        2'd1: acc <= prod;
        2'd2: acc <= acc + {prod[31:0], 32'h0};
        2'd3: acc <= acc + {prod[31:0], 32'h0};
        default: acc <= acc;
      endcase
    end
    if (cmd.latch) begin
      if (st.hit) begin
        ent_time  <= (func == FUNC_UPSERT) ? tm : rd.tm;
        ent_frame <= (func == FUNC_COUNT) ? rd.frame + 32'd1 : rd.frame;
      end else begin
        ent_time  <= tm;
        ent_frame <= 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      n           <= '0;
      count       <= '0;
      max_entries <= MAX_ENTRIES_RST;
    end else begin
      if (cmd.seed) begin
        idx <= h[IW-1:0];
        n   <= '0;
      end else if (cmd.step || cmd.clr_wr) begin
        idx <= idx + 1'b1;
        n   <= n + 1'b1;
      end
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end
      if (cfg_valid) begin
        max_entries <= cfg_data;
      end
    end
  end

  assign st.hit      = rd.valid && (rd.key == key);
  assign st.empty    = !rd.valid;
  assign st.last     = &n;
  assign st.full     = (EW'(count) >= EW'(max_entries)) || (count == CW'(TABLE_SLOTS));
  assign st.func     = func;
  assign st.out_busy = out_valid && !out_ready;

  assign wr_ent.valid = 1'b1;
  assign wr_ent.key   = key;
  assign wr_ent.tm    = ent_time;
  assign wr_ent.frame = ent_frame;

  assign ram_we    = cmd.wr || cmd.clr_wr;
  assign ram_waddr = idx;
  assign ram_wdata = cmd.clr_wr ? '0 : wr_ent;
  assign ram_re    = cmd.rd;
  assign ram_raddr = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      o_status <= cmd.res_status;
      if (cmd.res_entry) begin
        o_slot  <= SLOT_W'(idx);
        o_time  <= ent_time;
        o_frame <= ent_frame;
      end else begin
        o_slot  <= '0;
        o_time  <= '0;
        o_frame <= '0;
      end
    end
  end

  assign out_data = {{(OUT_W - SLOT_W - TIME_W - FRAME_W){1'b0}}, o_frame,
                     o_time[SEC_W-1:0], o_time[SEC_W+MIN_W-1:SEC_W],
                     o_time[TIME_W-1:SEC_W+MIN_W], o_slot};
  assign out_user = o_status;

  `CHK_SAME(a_count_cap, clk, rst, 1'b1, count <= CW'(TABLE_SLOTS), "entry count past table size")
  `CHK_SAME(a_one_port, clk, rst, ram_we, !ram_re, "table read and write in one cycle")

endmodule

// ----- rtl/core/mac_address_learning_table_top.sv -----
// Top level of the MAC address learning table.
//
//  channel  dir  handshake                   payload
//  s_axis   in   s_axis_tvalid/tready        tdata mac, hour, minute, second; tuser func
//  m_axis   out  m_axis_tvalid/tready        tdata slot, hour, minute, second, frames; tuser status
//  cfg      in   cfg_valid/cfg_ready         cfg_data max_entries
//
// A request runs from transfer to result through hash sequencing on one 32x32 multiplier,
// then one read and one compare of the table RAM for each slot probed, starting at the
// home slot, then a write of the entry when one is written, and then the result hand-off.
// After reset a clearing pass over all TABLE_SLOTS slots runs before the first request.
// The next request is taken while a result waits in the output register.
// TABLE_SLOTS must be a power of two.
`timescale 1ns / 1ps
module mac_address_learning_table_top #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // mac_address, seen_hour, seen_minute, seen_second
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // slot_index, stored_hour, stored_minute,
                                      // stored_second, frame_total
  output logic [2:0]  m_axis_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);
  import mlt_pkg::*;

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int EWID = $bits(mlt_entry_t);

  mlt_cmd_t        cmd;
  mlt_stat_t       st;
  logic            ram_we, ram_re;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  logic [EWID-1:0] ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  mlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mlt_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  mlt_ram #(
    .WIDTH (EWID),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
